// ===== src/sorted_id_remap_table_unit_macros.svh =====
// Assertion helpers for the checker file.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef SORTED_ID_REMAP_TABLE_UNIT_MACROS_SVH
`define SORTED_ID_REMAP_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_id_remap_table_unit: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_id_remap_table_unit: assertion failed");

`endif

// ===== src/sirt_pkg.sv =====
package sirt_pkg;

  localparam int unsigned ID_W            = 32;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  // Operation codes carried in the input tuser field.
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   key;
    logic [ID_W-1:0]   replacement;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            hit;
    logic            status;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } done_t;

  // Outcome of comparing a probed key against the search key.
  typedef struct packed {
    logic eq;
    logic lt;   // probed key is below the search key
  } cmp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LB_RD,
    ST_LB_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS,
    ST_SR_RD,
    ST_SR_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== src/sorted_id_remap_table_unit.sv =====
// Identifier remap table: holds up to TABLE_DEPTH pairs of an old 32-bit
// identifier and its replacement, kept sorted by old identifier in a single
// memory. Each input transaction carries an operation in in_tuser (load,
// lookup or clear) and answers with exactly one output transaction. A load
// binary-searches for the insertion point (a new key lands before equal
// keys), moves the tail of the table up one entry at a time and writes the
// pair; a load into a full table changes nothing and answers status 1. A
// lookup binary-searches for its key and answers the stored replacement with
// hit set, or the key itself when the key is absent or its replacement equals
// the no-replacement marker written on the cfg channel. A clear empties the
// table at once. All searches share one comparator and one memory read port,
// so each probe takes an address step and then a compare step. The block takes
// one transaction at a time; a finished result waits in the output register,
// so a stalled consumer only holds the block at its last step. The memory
// needs no clearing pass after reset.
module sorted_id_remap_table_unit #(
  parameter int unsigned TABLE_DEPTH = sirt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [2*sirt_pkg::ID_W-1:0]    in_tdata,   // key [31:0], replacement [63:32]
  input  logic [sirt_pkg::FUNC_W-1:0]    in_tuser,   // func [1:0]
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sirt_pkg::ID_W-1:0]      out_tdata,  // result_id [31:0]
  output logic [1:0]                     out_tuser,  // hit [0], status [1]
  // Configuration channel: no-replacement marker.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sirt_pkg::ID_W-1:0]      cfg_data
);
  import sirt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [ID_W-1:0] marker_r;
  logic            out_valid_r;
  res_t            out_res_r;
  logic            slot_free;
  req_t            req;
  done_t           done;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  entry_t          ram_rdata;

  // Unpack the incoming transaction.
  assign req.func        = in_tuser;
  assign req.key         = in_tdata[ID_W-1:0];
  assign req.replacement = in_tdata[2*ID_W-1:ID_W];

  // The marker register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
    end else if (cfg_valid) begin
      marker_r <= cfg_data;
    end
  end

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= done.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && done.valid) begin
      out_res_r <= done.res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_res_r.result_id;
  assign out_tuser[0] = out_res_r.hit;
  assign out_tuser[1] = out_res_r.status;

  sirt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .req       (req),
    .marker    (marker_r),
    .slot_free (slot_free),
    .ready     (in_tready),
    .done      (done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sirt_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== src/sirt_ram.sv =====
module sirt_ram #(
  parameter int unsigned DEPTH = sirt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [sirt_pkg::ENTRY_W-1:0]  wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [sirt_pkg::ENTRY_W-1:0]  rdata
);
  import sirt_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sirt_cmp.sv =====
module sirt_cmp (
  input  logic [sirt_pkg::ID_W-1:0] probe_key,
  input  logic [sirt_pkg::ID_W-1:0] key,
  output sirt_pkg::cmp_t            cmp
);
  import sirt_pkg::*;

  // Single magnitude comparator shared by insertion and lookup searches.
  assign cmp.eq = (probe_key == key);
  assign cmp.lt = (probe_key < key);

endmodule

// ===== src/sirt_ctrl.sv =====
module sirt_ctrl #(
  parameter int unsigned DEPTH = sirt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  sirt_pkg::req_t                req,
  input  logic [sirt_pkg::ID_W-1:0]     marker,
  input  logic                          slot_free,
  output logic                          ready,
  output sirt_pkg::done_t               done,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output sirt_pkg::entry_t              ram_wdata,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  sirt_pkg::entry_t              ram_rdata
);
  import sirt_pkg::*;

  state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic signed [CW:0]   hi_r, hi_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [ID_W-1:0]      key_r, key_nxt;
  logic [ID_W-1:0]      repl_r, repl_nxt;
  res_t                 res_r, res_nxt;

  cmp_t                 cmp;
  logic                 accept;
  logic                 full;
  logic                 lb_go;
  logic                 sr_go;
  logic [CW:0]          mid_sum;
  logic [AW-1:0]        mid_calc;
  logic [CW-1:0]        mid_cw;
  logic [CW-1:0]        idx_dec;

  sirt_cmp u_cmp (
    .probe_key (ram_rdata.key),
    .key       (key_r),
    .cmp       (cmp)
  );

  assign accept  = in_valid && (state_r == ST_IDLE);
  assign full    = (count_r == CW'(DEPTH));
  assign lb_go   = $signed({1'b0, lo_r}) < hi_r;
  assign sr_go   = $signed({1'b0, lo_r}) <= hi_r;
  // Only used while hi is not negative, so its low bits are its value.
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r[CW-1:0]};
  assign mid_calc = mid_sum[AW:1];
  assign mid_cw   = {{(CW-AW){1'b0}}, mid_r};
  assign idx_dec  = idx_r - CW'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (req.func)
            FUNC_LOAD:   state_nxt = full ? ST_DONE : ST_LB_RD;
            FUNC_LOOKUP: state_nxt = ST_SR_RD;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LB_RD:  state_nxt = lb_go ? ST_LB_CMP : ST_SH_RD;
      ST_LB_CMP: state_nxt = ST_LB_RD;
      ST_SH_RD:  state_nxt = (idx_r > lo_r) ? ST_SH_WR : ST_INS;
      ST_SH_WR:  state_nxt = ST_SH_RD;
      ST_INS:    state_nxt = ST_DONE;
      ST_SR_RD:  state_nxt = sr_go ? ST_SR_CMP : ST_DONE;
      ST_SR_CMP: state_nxt = cmp.eq ? ST_DONE : ST_SR_RD;
      ST_DONE:   state_nxt = slot_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshake and memory control.
  always_comb begin
    ready      = (state_r == ST_IDLE);
    done.valid = (state_r == ST_DONE);
    done.res   = res_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = mid_calc;
    case (state_r)
      ST_LB_RD: ram_re = lb_go;
      ST_SR_RD: ram_re = sr_go;
      ST_SH_RD: begin
        ram_re    = (idx_r > lo_r);
        ram_raddr = idx_dec[AW-1:0];
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
      end
      ST_INS: begin
        ram_we          = 1'b1;
        ram_waddr       = lo_r[AW-1:0];
        ram_wdata.key   = key_r;
        ram_wdata.value = repl_r;
      end
      default: begin
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    repl_nxt  = repl_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt        = req.key;
          repl_nxt       = req.replacement;
          lo_nxt         = '0;
          res_nxt        = '0;
          res_nxt.status = (req.func == FUNC_LOAD) && full;
          if (req.func == FUNC_LOOKUP) begin
            hi_nxt = $signed({1'b0, count_r}) - $signed((CW+1)'(1));
          end else begin
            hi_nxt = $signed({1'b0, count_r});
          end
          if (req.func == FUNC_CLEAR) begin
            count_nxt = '0;
          end
        end
      end
      ST_LB_RD: begin
        mid_nxt = mid_calc;
        idx_nxt = count_r;
      end
      ST_LB_CMP: begin
        if (cmp.lt) begin
          lo_nxt = mid_cw + CW'(1);
        end else begin
          hi_nxt = $signed({1'b0, mid_cw});
        end
      end
      ST_SH_WR: idx_nxt = idx_dec;
      ST_INS:   count_nxt = count_r + CW'(1);
      ST_SR_RD: begin
        mid_nxt = mid_calc;
        if (!sr_go) begin
          res_nxt.result_id = key_r;
        end
      end
      ST_SR_CMP: begin
        if (cmp.eq) begin
          if (ram_rdata.value != marker) begin
            res_nxt.result_id = ram_rdata.value;
            res_nxt.hit       = 1'b1;
          end else begin
            res_nxt.result_id = key_r;
          end
        end else if (cmp.lt) begin
          lo_nxt = mid_cw + CW'(1);
        end else begin
          hi_nxt = $signed({1'b0, mid_cw}) - $signed((CW+1)'(1));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    idx_r  <= idx_nxt;
    key_r  <= key_nxt;
    repl_r <= repl_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== src/sirt_checker.sv =====
`include "sorted_id_remap_table_unit_macros.svh"

module sirt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result keeps its contents.
  `SIRT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // The block works on one transaction at a time.
  `SIRT_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // A refused load carries no lookup answer.
  `SIRT_ASSERT_IMP(a_refused_clean, out_tvalid && out_tuser[1], out_tdata == 32'd0 && !out_tuser[0])

  // Hit and refusal never come together.
  `SIRT_ASSERT_IMP(a_hit_or_status, out_tvalid, !(out_tuser[0] && out_tuser[1]))

endmodule

bind sorted_id_remap_table_unit sirt_checker u_sirt_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
  import sirt_pkg::*;

  // The table depth that the block is built with; the shadow table matches it.
  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  // Code three is not an operation: the block must answer it and change nothing.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Random part: roughly this many loads, lookups and clears.
  localparam int unsigned RANDOM_ITEMS = 1100;

  // A load that moves the whole table is the longest operation. On top
  // of it come the longest sender gap and consumer stall, and a wide margin.
  localparam int unsigned QUIET_LIMIT = 4000;

  // Cycles to watch for a stray result once every answer has arrived.
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [2*ID_W-1:0]    in_tdata;    // key [31:0], replacement [63:32]
  logic [FUNC_W-1:0]    in_tuser;    // func [1:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [ID_W-1:0]      out_tdata;   // result_id [31:0]
  logic [1:0]           out_tuser;   // hit [0], status [1]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [ID_W-1:0]      cfg_data;

  sorted_id_remap_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's table, kept sorted by key exactly as the block
  // keeps it, together with the entry count and the no-replacement marker.
  logic [ID_W-1:0] shadow_keys   [DEPTH];
  logic [ID_W-1:0] shadow_values [DEPTH];
  int unsigned     shadow_count;
  logic [ID_W-1:0] shadow_marker;

  // Answers owed by the block, oldest first, one per accepted input transaction.
  res_t pending_answers[$];

  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned loads_done;
  int unsigned loads_refused;
  int unsigned lookup_hits;
  int unsigned lookup_misses;
  int unsigned clears_done;
  int unsigned marker_writes;

  // When set, that side of the block runs back to back without idle cycles.
  bit in_no_idle;
  bit out_no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Expected behavior
  // ---------------------------------------------------------------------------

  // First position whose key is not below k: a new key goes before equal keys.
  function automatic int unsigned insert_point(logic [ID_W-1:0] k);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Classic binary search probing (lo + hi) / 2. With duplicate keys the first
  // probed match wins, so the exact probe order matters.
  function automatic int find_key(logic [ID_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(shadow_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (k == shadow_keys[mid]) return mid;
      if (k < shadow_keys[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  // Applies one operation to the shadow table and returns the answer owed.
  function automatic res_t remap_predict(logic [FUNC_W-1:0] func, logic [ID_W-1:0] key,
                                         logic [ID_W-1:0] repl);
    res_t        answer;
    int unsigned pos;
    int unsigned i;
    int          idx;
    answer = '0;
    case (func)
      FUNC_LOAD: begin
        if (shadow_count >= DEPTH) begin
          // A full table refuses the pair and stays as it is.
          answer.status = 1'b1;
          loads_refused++;
        end else begin
          pos = insert_point(key);
          for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_values[i] = shadow_values[i-1];
          end
          shadow_keys[pos]   = key;
          shadow_values[pos] = repl;
          shadow_count++;
          loads_done++;
        end
      end
      FUNC_LOOKUP: begin
        idx = find_key(key);
        answer.result_id = key;
        if (idx >= 0 && shadow_values[idx] != shadow_marker) begin
          answer.result_id = shadow_values[idx];
          answer.hit       = 1'b1;
          lookup_hits++;
        end else begin
          lookup_misses++;
        end
      end
      FUNC_CLEAR: begin
        shadow_count = 0;
        clears_done++;
      end
      default: begin
        // Unused code: all-zero answer, no change.
      end
    endcase
    return answer;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  // Sends one input transaction after a random gap. Valid stays high into the
  // next call when that call draws no gap, so a back-to-back stream is never
  // broken by a low-then-high pair in one time step.
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] key,
                           input logic [ID_W-1:0] repl);
    int unsigned gap;
    gap = draw_wait(in_no_idle);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {repl, key};
    in_tuser  <= func;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pending_answers.push_back(remap_predict(func, key, repl));
  endtask

  // Lowers the input valid and waits until every answer owed has arrived, at
  // which point the block holds nothing and may take a marker write.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_marker(input logic [ID_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_marker = value;
    marker_writes++;
  endtask

  task automatic report_mismatch(input string what, input int unsigned num,
                                 input logic [ID_W-1:0] got, input logic [ID_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH result %0d %s: got %h expected %h", num, what, got, want);
  endtask

  // Key styles: fully random, a narrow range that forces many duplicates, and
  // clusters at both ends of the key range.
  function automatic logic [ID_W-1:0] draw_key(int unsigned style);
    case (style)
      0:       return $urandom;
      1:       return $urandom_range(0, 31);
      default: return {($urandom_range(0, 1) ? 4'hF : 4'h0), 28'($urandom_range(0, 63))};
    endcase
  endfunction

  // Most lookups aim at stored keys or their direct neighbors.
  function automatic logic [ID_W-1:0] pick_lookup_key(int unsigned style);
    logic [ID_W-1:0] k;
    int unsigned     pick;
    pick = $urandom_range(0, 9);
    if (shadow_count == 0 || pick >= 8) return draw_key(style);
    k = shadow_keys[$urandom_range(0, shadow_count - 1)];
    if (pick == 6) k = k + 1;
    else if (pick == 7) k = k - 1;
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Draws a stall before each result and then compares every accepted result,
  // field by field, with the oldest answer owed.
  initial begin : result_check
    int unsigned stall;
    res_t        want;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait(out_no_idle);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      results_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("arrived with no transaction owed", results_seen, out_tdata, '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata !== want.result_id)
          report_mismatch("result_id", results_seen, out_tdata, want.result_id);
        if (out_tuser[0] !== want.hit)
          report_mismatch("hit", results_seen, ID_W'(out_tuser[0]), ID_W'(want.hit));
        if (out_tuser[1] !== want.status)
          report_mismatch("status", results_seen, ID_W'(out_tuser[1]), ID_W'(want.status));
      end
    end
  end

  // Ends the run when no transaction on any channel has completed for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d answers owed", quiet,
                 pending_answers.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lookups on a table that has never held anything, a clear of an empty
  // table and the unused code with every input bit set.
  task automatic test_empty_table();
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_LOOKUP, $urandom, $urandom);
  endtask

  // Extreme keys and replacements, a replacement equal to the marker (zero
  // after reset), a key stored three times, absent neighbors, and a clear.
  task automatic test_directed_ops();
    send_item(FUNC_LOAD, 32'h8000_0000, 32'h1234_5678);
    send_item(FUNC_LOAD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(FUNC_LOAD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'h8000_0000, 32'hAAAA_5555);
    send_item(FUNC_LOAD, 32'h8000_0000, 32'h5555_AAAA);
    send_item(FUNC_LOAD, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h8000_0001, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(FUNC_UNUSED, 32'h8000_0000, 32'h1234_5678);
    send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_item(FUNC_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_item(FUNC_LOAD, 32'h0000_0005, 32'h0000_0006);
    send_item(FUNC_LOOKUP, 32'h0000_0005, 32'h0000_0000);
    send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Fills the table with falling keys so that every load moves the whole
  // stored tail, then checks refusal, lookups over a full table and a clear.
  task automatic test_full_table();
    logic [ID_W-1:0] key;
    int unsigned     i;
    send_item(FUNC_CLEAR, '0, '0);
    key = 32'hFFFF_FFFF;
    for (i = 0; i < DEPTH; i++) begin
      // Every seventh pair repeats the previous key.
      if (i % 7 != 6) key = (DEPTH - i) * 32'h00FF_FFFF + $urandom_range(0, 3);
      send_item(FUNC_LOAD, key, ($urandom_range(0, 9) == 0) ? shadow_marker : $urandom);
    end
    send_item(FUNC_LOAD, 32'h0000_0000, 32'h0000_0001);
    send_item(FUNC_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (i = 0; i < 40; i++)
      send_item(FUNC_LOOKUP, pick_lookup_key(0), $urandom);
    send_item(FUNC_LOOKUP, shadow_keys[0], '0);
    send_item(FUNC_LOOKUP, shadow_keys[DEPTH-1], '0);
    send_item(FUNC_UNUSED, $urandom, $urandom);
    send_item(FUNC_CLEAR, '0, '0);
    send_item(FUNC_LOOKUP, key, '0);
  endtask

  // Marker at all ones, at a random value and back at zero. Pairs store the
  // marker itself and its neighbors, which must still count as replacements.
  task automatic test_marker_settings();
    logic [ID_W-1:0] settings [3];
    logic [ID_W-1:0] m;
    int unsigned     s;
    int unsigned     i;
    settings[0] = 32'hFFFF_FFFF;
    settings[1] = $urandom;
    settings[2] = 32'h0000_0000;
    for (s = 0; s < 3; s++) begin
      m = settings[s];
      write_marker(m);
      send_item(FUNC_CLEAR, '0, '0);
      send_item(FUNC_LOAD, 32'h0000_0010, m);
      send_item(FUNC_LOAD, 32'h0000_0020, m ^ 32'h1);
      send_item(FUNC_LOAD, 32'h0000_0030, ~m);
      send_item(FUNC_LOAD, 32'h0000_0010, m + 1);
      for (i = 1; i <= 3; i++)
        send_item(FUNC_LOOKUP, i * 32'h10, '0);
    end
  endtask

  // Phases of an optional clear, a batch of loads and a batch of lookups with random
  // content, sprinkled with unused codes and stray operations. Marker writes
  // and idle styles change between phases; now and then a phase runs the
  // table past full.
  task automatic test_random_phases();
    int unsigned     counted;
    int unsigned     style;
    int unsigned     n;
    int unsigned     i;
    int unsigned     pick;
    logic [ID_W-1:0] m;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      in_no_idle  = ($urandom_range(0, 3) == 0);
      out_no_idle = ($urandom_range(0, 3) == 0);
      style = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) m = 32'h0000_0000;
        else if (pick == 1) m = 32'hFFFF_FFFF;
        else if (pick == 2 && shadow_count != 0)
          m = shadow_values[$urandom_range(0, shadow_count - 1)];
        else m = $urandom;
        write_marker(m);
      end
      if ($urandom_range(0, 3) != 0) begin
        send_item(FUNC_CLEAR, $urandom, $urandom);
        counted++;
      end
      n = ($urandom_range(0, 11) == 0) ? DEPTH + 2 : $urandom_range(1, 40);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(FUNC_UNUSED, $urandom, $urandom);
        end else begin
          send_item(FUNC_LOAD, draw_key(style),
                    ($urandom_range(0, 5) == 0) ? shadow_marker : $urandom);
          counted++;
        end
      end
      n = $urandom_range(5, 40);
      for (i = 0; i < n; i++) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
          send_item(FUNC_CLEAR, $urandom, $urandom);
          counted++;
        end else if (pick == 1) begin
          send_item(FUNC_UNUSED, $urandom, $urandom);
        end else if (pick == 2) begin
          send_item(FUNC_LOAD, pick_lookup_key(style), $urandom);
          counted++;
        end else begin
          send_item(FUNC_LOOKUP, pick_lookup_key(style), $urandom);
          counted++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_LOAD;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    shadow_count   = 0;
    shadow_marker  = '0;
    mismatch_count = 0;
    results_seen   = 0;
    loads_done     = 0;
    loads_refused  = 0;
    lookup_hits    = 0;
    lookup_misses  = 0;
    clears_done    = 0;
    marker_writes  = 0;
    in_no_idle     = 1'b0;
    out_no_idle    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_ops();
    test_full_table();
    test_marker_settings();
    test_random_phases();

    // Every answer must arrive, and nothing may follow the last one.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d results: %0d pairs stored, %0d loads refused as full, %0d clears.",
             results_seen, loads_done, loads_refused, clears_done);
    $display("Lookups: %0d hits, %0d misses; %0d marker writes; %0d mismatches.",
             lookup_hits, lookup_misses, marker_writes, mismatch_count);
    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
